// ----- rtl/macd_pkg.sv -----
// Package for the MACD 12/26/9 indicator filter: widths, fixed-point constants, types and
// the small arithmetic helpers of the datapath. No dependencies.
`default_nettype none

package macd_pkg;

  // Indicator periods.
  localparam int SHORT_PERIOD  = 12;
  localparam int LONG_PERIOD   = 26;
  localparam int SIGNAL_PERIOD = 9;

  // Field widths. Averages are Q24.16, the MACD and signal lines are signed Q24.16.
  localparam int PRICE_W = 24;
  localparam int FRAC_W  = 16;
  localparam int AVG_W   = PRICE_W + FRAC_W;
  localparam int LINE_W  = AVG_W + 1;
  localparam int Q_ONE   = 1 << FRAC_W;
  localparam int ALPHA_W = FRAC_W;

  // Sample numbering.
  localparam int MAX_PERIOD = (SHORT_PERIOD > LONG_PERIOD) ? SHORT_PERIOD : LONG_PERIOD;
  localparam int COUNT_CAP  = MAX_PERIOD + SIGNAL_PERIOD;
  localparam int COUNT_W    = $clog2(COUNT_CAP + 1);

  // Smoothing factors 2/(N+1) in Q0.16, rounded to nearest.
  localparam logic [ALPHA_W-1:0] ALPHA_SHORT =
    ALPHA_W'((2 * Q_ONE + (SHORT_PERIOD + 1) / 2) / (SHORT_PERIOD + 1));
  localparam logic [ALPHA_W-1:0] ALPHA_LONG =
    ALPHA_W'((2 * Q_ONE + (LONG_PERIOD + 1) / 2) / (LONG_PERIOD + 1));
  localparam logic [ALPHA_W-1:0] ALPHA_SIGNAL =
    ALPHA_W'((2 * Q_ONE + (SIGNAL_PERIOD + 1) / 2) / (SIGNAL_PERIOD + 1));

  // Constant divider. A value v * 2^16 + w is split as v * (c*N + d) + w, so only the
  // narrow term v*d + w goes through a reciprocal multiply with a one-step correction.
  localparam int DIV_T_W = 31;
  localparam int RCP_W   = 32;
  localparam int PROD_W  = DIV_T_W + RCP_W;
  localparam int REM_W   = 8;

  typedef logic [REM_W-1:0] rem_t;

  localparam rem_t NDIV_S = REM_W'(SHORT_PERIOD);
  localparam rem_t NDIV_L = REM_W'(LONG_PERIOD);
  localparam rem_t NDIV_G = REM_W'(SIGNAL_PERIOD);

  localparam logic [FRAC_W-1:0] DQUO_S = FRAC_W'(Q_ONE / SHORT_PERIOD);
  localparam logic [FRAC_W-1:0] DQUO_L = FRAC_W'(Q_ONE / LONG_PERIOD);
  localparam logic [FRAC_W-1:0] DQUO_G = FRAC_W'(Q_ONE / SIGNAL_PERIOD);

  localparam rem_t DREM_S = REM_W'(Q_ONE % SHORT_PERIOD);
  localparam rem_t DREM_L = REM_W'(Q_ONE % LONG_PERIOD);
  localparam rem_t DREM_G = REM_W'(Q_ONE % SIGNAL_PERIOD);

  localparam logic [RCP_W-1:0] RCP_S = RCP_W'((longint'(1) << RCP_W) / SHORT_PERIOD);
  localparam logic [RCP_W-1:0] RCP_L = RCP_W'((longint'(1) << RCP_W) / LONG_PERIOD);
  localparam logic [RCP_W-1:0] RCP_G = RCP_W'((longint'(1) << RCP_W) / SIGNAL_PERIOD);

  // Remainder at or above this rounds the seed mean up.
  localparam rem_t HALF_S = REM_W'((SHORT_PERIOD + 1) / 2);
  localparam rem_t HALF_L = REM_W'((LONG_PERIOD + 1) / 2);
  localparam rem_t HALF_G = REM_W'((SIGNAL_PERIOD + 1) / 2);

  // Offset that keeps the signed narrow term of the signal divider non-negative.
  localparam int GOFF = 1 << PRICE_W;
  localparam logic signed [DIV_T_W:0] GBIAS =
    (DIV_T_W + 1)'(longint'(SIGNAL_PERIOD) << PRICE_W);

  typedef logic [PRICE_W-1:0]        price_t;
  typedef logic [AVG_W-1:0]          avg_t;
  typedef logic signed [LINE_W-1:0]  line_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef struct packed {
    logic [DIV_T_W-1:0] q;
    rem_t               r;
  } cdiv_t;

  typedef struct packed {
    logic carry;
    rem_t r;
  } rem_sum_t;

  // Final step of the constant divider: the reciprocal estimate is low by at most one.
  function automatic cdiv_t cdiv_fix(input logic [DIV_T_W-1:0] t,
                                     input logic [PROD_W-1:0]  prod,
                                     input rem_t               n);
    logic [DIV_T_W-1:0] q0;
    logic [2*REM_W-1:0] qn;
    rem_t               r0;
    cdiv_t              res;
    q0 = prod[PROD_W-1:RCP_W];
    qn = q0[REM_W-1:0] * n;
    r0 = t[REM_W-1:0] - qn[REM_W-1:0];
    if (r0 >= n) begin
      res.q = q0 + 1'b1;
      res.r = r0 - n;
    end else begin
      res.q = q0;
      res.r = r0;
    end
    return res;
  endfunction

  // Adds two remainders modulo n and reports the carry into the quotient.
  function automatic rem_sum_t rem_add(input rem_t r, input rem_t xr, input rem_t n);
    rem_t     s;
    rem_sum_t res;
    s         = r + xr;
    res.carry = (s >= n);
    res.r     = res.carry ? rem_t'(s - n) : s;
    return res;
  endfunction

  // Unsigned EMA step with round half up: (avg*(1-a) + x*a) in Q0.16, x = price << 16.
  function automatic avg_t ema_u(input avg_t avg, input price_t p,
                                 input logic [ALPHA_W-1:0] alpha);
    localparam int ACC_W = AVG_W + ALPHA_W + 1;
    logic [ALPHA_W-1:0]         keep;
    logic [PRICE_W+ALPHA_W-1:0] pa;
    logic [ACC_W-1:0]           acc;
    keep = ALPHA_W'(Q_ONE - int'(alpha));
    pa   = (PRICE_W + ALPHA_W)'(p) * (PRICE_W + ALPHA_W)'(alpha);
    acc  = ACC_W'(avg) * ACC_W'(keep) + ACC_W'({pa, {FRAC_W{1'b0}}}) + ACC_W'(Q_ONE / 2);
    return acc[FRAC_W +: AVG_W];
  endfunction

  // Signed EMA step, rounding half up toward plus infinity.
  function automatic line_t ema_s(input line_t avg, input line_t m,
                                  input logic [ALPHA_W-1:0] alpha);
    localparam int SACC_W = LINE_W + ALPHA_W + 2;
    logic signed [ALPHA_W+1:0] keep_s;
    logic signed [ALPHA_W+1:0] alpha_s;
    logic signed [SACC_W-1:0]  acc;
    keep_s  = $signed((ALPHA_W + 2)'(Q_ONE - int'(alpha)));
    alpha_s = $signed({2'b00, alpha});
    acc     = SACC_W'(avg) * SACC_W'(keep_s) + SACC_W'(m) * SACC_W'(alpha_s)
            + SACC_W'(Q_ONE / 2);
    return acc[FRAC_W +: LINE_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/macd_indicator_filter.sv -----
// MACD 12/26/9 indicator filter top level: price pre-division, short and long averages,
// MACD difference, signal average and output register. Depends on macd_pkg.
// Throughput: one transaction per cycle while out_ready_i does not stall the output; the
// feedback loops of the three averages each close inside one pipeline stage, and the
// constant dividers are fed forward in 3 stages.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears the sample count,
// the seed sums and the averages.
`default_nettype none

module macd_indicator_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [macd_pkg::PRICE_W-1:0]        close_price_i,
  input  logic                                series_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [macd_pkg::LINE_W-1:0]  macd_line_o,
  output logic signed [macd_pkg::LINE_W-1:0]  signal_line_o,
  output logic                                macd_valid_o,
  output logic                                signal_valid_o
);
  import macd_pkg::*;

  // Pipeline stage positions.
  localparam int S_IN   = 0;  // input register
  localparam int S_MUL  = 1;  // price times divider constants
  localparam int S_RCP  = 2;  // reciprocal multiply
  localparam int S_FIX  = 3;  // quotient correction, price / N ready
  localparam int S_AVG  = 4;  // sample count, seeds and short/long averages
  localparam int S_DIFF = 5;  // MACD line
  localparam int S_GMUL = 6;  // MACD times divider constants
  localparam int S_GRCP = 7;  // reciprocal multiply
  localparam int S_GFIX = 8;  // quotient correction, MACD / N ready
  localparam int S_OUT  = 9;  // signal average and result register
  localparam int NSTG   = 10;

  // Stage handshake. A stage takes a new transaction when it is empty or when the stage
  // after it takes its current one, so bubbles close up and the input keeps flowing
  // while a finished result waits at the output, until every stage is full.
  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] ready;
  logic [NSTG-1:0] up_valid;
  logic [NSTG-1:0] load;

  assign ready[NSTG-1] = !valid_q[NSTG-1] || out_ready_i;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_ready
    assign ready[k] = !valid_q[k] || ready[k+1];
  end

  assign up_valid = {valid_q[NSTG-2:0], in_valid_i};
  assign load     = ready & up_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (ready[k]) begin
          valid_q[k] <= up_valid[k];
        end
      end
    end
  end

  assign in_ready_o  = ready[S_IN];
  assign out_valid_o = valid_q[S_OUT];

  // ---------------------------------------------------------------------------------------
  // Price path. Each seed sum is kept as quotient and remainder by N, so the seed mean is
  // a quotient plus a rounding bit. Each sample's price << 16 is divided by N ahead of time.
  // ---------------------------------------------------------------------------------------
  price_t                price0_q, price1_q, price2_q, price3_q;
  logic                  start0_q, start1_q, start2_q, start3_q;
  logic [DIV_T_W-1:0]    ts1_q, tl1_q, ts2_q, tl2_q;
  avg_t                  pcs1_q, pcl1_q, pcs2_q, pcl2_q;
  logic [PROD_W-1:0]     prods2_q, prodl2_q;
  avg_t                  xqs3_q, xql3_q;
  rem_t                  xrs3_q, xrl3_q;
  cdiv_t                 fix_s, fix_l;

  assign fix_s = cdiv_fix(ts2_q, prods2_q, NDIV_S);
  assign fix_l = cdiv_fix(tl2_q, prodl2_q, NDIV_L);

  always_ff @(posedge clk_i) begin
    if (load[S_IN]) begin
      price0_q <= close_price_i;
      start0_q <= series_start_i;
    end
    if (load[S_MUL]) begin
      price1_q <= price0_q;
      start1_q <= start0_q;
      ts1_q    <= DIV_T_W'(price0_q) * DIV_T_W'(DREM_S);
      tl1_q    <= DIV_T_W'(price0_q) * DIV_T_W'(DREM_L);
      pcs1_q   <= AVG_W'(price0_q) * AVG_W'(DQUO_S);
      pcl1_q   <= AVG_W'(price0_q) * AVG_W'(DQUO_L);
    end
    if (load[S_RCP]) begin
      price2_q <= price1_q;
      start2_q <= start1_q;
      ts2_q    <= ts1_q;
      tl2_q    <= tl1_q;
      pcs2_q   <= pcs1_q;
      pcl2_q   <= pcl1_q;
      prods2_q <= PROD_W'(ts1_q) * PROD_W'(RCP_S);
      prodl2_q <= PROD_W'(tl1_q) * PROD_W'(RCP_L);
    end
    if (load[S_FIX]) begin
      price3_q <= price2_q;
      start3_q <= start2_q;
      xqs3_q   <= pcs2_q + AVG_W'(fix_s.q);
      xrs3_q   <= fix_s.r;
      xql3_q   <= pcl2_q + AVG_W'(fix_l.q);
      xrl3_q   <= fix_l.r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Averaging stage. The state registers double as this stage's payload: they change only
  // when a transaction enters the stage, so they always belong to the one held here.
  // ---------------------------------------------------------------------------------------
  count_t   count_q;
  avg_t     short_avg_q, long_avg_q;
  avg_t     qs_q, ql_q;
  rem_t     rs_q, rl_q;
  logic     start4_q;

  count_t   cnt_base, n_cur;
  avg_t     qs_base, ql_base, qs_new, ql_new, seed_s, seed_l;
  rem_t     rs_base, rl_base;
  rem_sum_t rs_add, rl_add;

  always_comb begin
    // A series start clears the count and the seed sums before this sample is used.
    cnt_base = start3_q ? '0 : count_q;
    n_cur    = (cnt_base >= COUNT_W'(COUNT_CAP)) ? COUNT_W'(COUNT_CAP)
                                                 : count_t'(cnt_base + 1'b1);
    qs_base  = start3_q ? '0 : qs_q;
    rs_base  = start3_q ? '0 : rs_q;
    ql_base  = start3_q ? '0 : ql_q;
    rl_base  = start3_q ? '0 : rl_q;
    rs_add   = rem_add(rs_base, xrs3_q, NDIV_S);
    rl_add   = rem_add(rl_base, xrl3_q, NDIV_L);
    qs_new   = qs_base + xqs3_q + AVG_W'(rs_add.carry);
    ql_new   = ql_base + xql3_q + AVG_W'(rl_add.carry);
    seed_s   = qs_new + AVG_W'(rs_add.r >= HALF_S);
    seed_l   = ql_new + AVG_W'(rl_add.r >= HALF_L);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      short_avg_q <= '0;
      long_avg_q  <= '0;
      qs_q        <= '0;
      rs_q        <= '0;
      ql_q        <= '0;
      rl_q        <= '0;
    end else if (load[S_AVG]) begin
      count_q <= n_cur;
      // Short average: seed with the mean of the first samples, then run the EMA.
      if (n_cur <= COUNT_W'(SHORT_PERIOD)) begin
        qs_q <= qs_new;
        rs_q <= rs_add.r;
        if (n_cur == COUNT_W'(SHORT_PERIOD)) begin
          short_avg_q <= seed_s;
        end
      end else begin
        short_avg_q <= ema_u(short_avg_q, price3_q, ALPHA_SHORT);
      end
      // Long average, same scheme.
      if (n_cur <= COUNT_W'(LONG_PERIOD)) begin
        ql_q <= ql_new;
        rl_q <= rl_add.r;
        if (n_cur == COUNT_W'(LONG_PERIOD)) begin
          long_avg_q <= seed_l;
        end
      end else begin
        long_avg_q <= ema_u(long_avg_q, price3_q, ALPHA_LONG);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[S_AVG]) begin
      start4_q <= start3_q;
    end
  end

  // ---------------------------------------------------------------------------------------
  // MACD path: difference of the averages, then its division by the signal period, split
  // as macd = mh * 2^16 + ml with the signed narrow term biased to stay non-negative.
  // ---------------------------------------------------------------------------------------
  line_t                        macd5_q, macd6_q, macd7_q, macd8_q;
  count_t                       n5_q, n6_q, n7_q, n8_q;
  logic                         start5_q, start6_q, start7_q, start8_q;
  logic [DIV_T_W-1:0]           tg6_q, tg7_q;
  line_t                        mc6_q, mc7_q;
  logic [PROD_W-1:0]            prodg7_q;
  line_t                        qm8_q;
  rem_t                         rm8_q;

  logic signed [LINE_W-FRAC_W-1:0] mh6;
  logic [FRAC_W-1:0]               ml6;
  logic signed [DIV_T_W:0]         tg_full;
  cdiv_t                           fix_g;
  logic signed [LINE_W:0]          qm_wide;

  assign mh6     = $signed(macd5_q[LINE_W-1:FRAC_W]);
  assign ml6     = macd5_q[FRAC_W-1:0];
  assign tg_full = (DIV_T_W + 1)'(mh6) * $signed((DIV_T_W + 1)'(DREM_G))
                 + $signed((DIV_T_W + 1)'(ml6)) + GBIAS;
  assign fix_g   = cdiv_fix(tg7_q, prodg7_q, NDIV_G);
  // Remove the bias again: floor(macd / N) = mh*c + floor(biased term / N) - 2^24.
  assign qm_wide = (LINE_W + 1)'(mc7_q) + $signed((LINE_W + 1)'(fix_g.q))
                 - $signed((LINE_W + 1)'(GOFF));

  always_ff @(posedge clk_i) begin
    if (load[S_DIFF]) begin
      macd5_q  <= LINE_W'(short_avg_q) - LINE_W'(long_avg_q);
      n5_q     <= count_q;
      start5_q <= start4_q;
    end
    if (load[S_GMUL]) begin
      macd6_q  <= macd5_q;
      n6_q     <= n5_q;
      start6_q <= start5_q;
      tg6_q    <= tg_full[DIV_T_W-1:0];
      mc6_q    <= LINE_W'(mh6) * $signed(LINE_W'(DQUO_G));
    end
    if (load[S_GRCP]) begin
      macd7_q  <= macd6_q;
      n7_q     <= n6_q;
      start7_q <= start6_q;
      tg7_q    <= tg6_q;
      mc7_q    <= mc6_q;
      prodg7_q <= PROD_W'(tg6_q) * PROD_W'(RCP_G);
    end
    if (load[S_GFIX]) begin
      macd8_q  <= macd7_q;
      n8_q     <= n7_q;
      start8_q <= start7_q;
      qm8_q    <= qm_wide[LINE_W-1:0];
      rm8_q    <= fix_g.r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Signal average and result register. The MACD line is valid once both averages are
  // seeded; the signal seed collects the next SIGNAL_PERIOD MACD values, its mean is taken
  // on the last of them, and the signal EMA runs from the sample after that.
  // ---------------------------------------------------------------------------------------
  line_t    sig_avg_q;
  line_t    qg_q;
  rem_t     rg_q;
  line_t    macd_line_q, signal_line_q;
  logic     macd_valid_q, signal_valid_q;

  logic     mvalid, svalid, sig_seeding, sig_seed_last;
  line_t    qg_base, qg_new, seed_g, sig_next;
  rem_t     rg_base;
  rem_sum_t rg_add;

  always_comb begin
    mvalid        = (n8_q >= COUNT_W'(MAX_PERIOD));
    svalid        = (n8_q >= COUNT_W'(COUNT_CAP - 1));
    sig_seeding   = mvalid && (n8_q < COUNT_W'(COUNT_CAP));
    sig_seed_last = (n8_q == COUNT_W'(COUNT_CAP - 1));
    qg_base       = start8_q ? '0 : qg_q;
    rg_base       = start8_q ? '0 : rg_q;
    rg_add        = rem_add(rg_base, rm8_q, NDIV_G);
    qg_new        = qg_base + qm8_q + LINE_W'(rg_add.carry);
    seed_g        = qg_new + LINE_W'(rg_add.r >= HALF_G);
    if (sig_seed_last) begin
      sig_next = seed_g;
    end else begin
      sig_next = ema_s(sig_avg_q, macd8_q, ALPHA_SIGNAL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_avg_q <= '0;
      qg_q      <= '0;
      rg_q      <= '0;
    end else if (load[S_OUT]) begin
      if (sig_seeding) begin
        qg_q <= qg_new;
        rg_q <= rg_add.r;
      end else if (start8_q) begin
        qg_q <= '0;
        rg_q <= '0;
      end
      if (svalid) begin
        sig_avg_q <= sig_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[S_OUT]) begin
      macd_line_q    <= mvalid ? macd8_q : '0;
      signal_line_q  <= svalid ? sig_next : '0;
      macd_valid_q   <= mvalid;
      signal_valid_q <= svalid;
    end
  end

  assign macd_line_o    = macd_line_q;
  assign signal_line_o  = signal_line_q;
  assign macd_valid_o   = macd_valid_q;
  assign signal_valid_o = signal_valid_q;

endmodule

`default_nettype wire

// ----- rtl/macd_chk.sv -----
// Port-level checker for the MACD indicator filter and the bind that attaches it.
// Depends on macd_pkg and on the top level macd_indicator_filter.
`default_nettype none

module macd_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [macd_pkg::LINE_W-1:0]  macd_line_o,
  input logic signed [macd_pkg::LINE_W-1:0]  signal_line_o,
  input logic                                macd_valid_o,
  input logic                                signal_valid_o
);

  // The signal line can only be valid once the MACD line is.
  a_sig_needs_macd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!signal_valid_o || macd_valid_o))
    else $error("signal_valid without macd_valid");

  // An unseeded MACD line reads as zero.
  a_macd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !macd_valid_o) |-> (macd_line_o == '0))
    else $error("macd_line nonzero while not valid");

  // An unseeded signal line reads as zero.
  a_sig_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !signal_valid_o) |-> (signal_line_o == '0))
    else $error("signal_line nonzero while not valid");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(macd_line_o) && $stable(signal_line_o)))
    else $error("result changed while stalled");

endmodule

bind macd_indicator_filter macd_chk u_macd_chk (.*);

`default_nettype wire
